// ===== rtl/srtf_pkg.sv =====
// shared types and constants of the srtf scheduler
// holds command codes, field widths and the controller/datapath link structs
// depends on nothing
package srtf_pkg;

  // field widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned TIME_W    = 21;
  localparam int unsigned SUM_W     = 25;
  localparam int unsigned PIDX_W    = 4;
  localparam int unsigned CMD_W     = 2;

  // saturation limits
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // append a process
    logic clear;     // empty table, restart time and totals
    logic tick_init; // restart scan, drop last pick
    logic scan_rd;   // read the table entry under the scan pointer
    logic step;      // run the pick for one unit, advance time
    logic tat_en;    // capture turnaround
    logic wt_en;     // capture waiting, add turnaround total
    logic sum_en;    // add waiting total
    logic report;    // load result registers
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last; // scan pointer on the last loaded entry
    logic all_done;  // every loaded process completed
  } dp_sts_t;

endpackage

// ===== rtl/srtf_ram.sv =====
// generic single write, single read port ram with registered read data
// no reset on the storage, depends on nothing
module srtf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/srtf_ctrl.sv =====
// control state machine of the srtf scheduler
// sequences load, clear and tick; uses srtf_pkg
module srtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        command_i,
  input  srtf_pkg::dp_sts_t sts_i,
  output srtf_pkg::dp_cmd_t cmd_o,
  output logic              busy,
  output logic              result_valid_o
);
  import srtf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STEP,
    ST_TURN,
    ST_WAIT,
    ST_ACCUM,
    ST_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_LOAD:  cmd_o.load = 1'b1;
            CMD_CLEAR: cmd_o.clear = 1'b1;
            CMD_TICK: begin
              cmd_o.tick_init = 1'b1;
              state_d = sts_i.all_done ? ST_REPORT : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_STEP;
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_TURN;
      end
      ST_TURN: begin
        cmd_o.tat_en = 1'b1;
        state_d      = ST_WAIT;
      end
      ST_WAIT: begin
        cmd_o.wt_en = 1'b1;
        state_d     = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_REPORT;
      end
      ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= (state_q == ST_REPORT);
    end
  end

endmodule

// ===== rtl/srtf_dpath.sv =====
// datapath of the srtf scheduler: process tables, scan compare, time and totals
// uses srtf_pkg and srtf_ram
module srtf_dpath #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srtf_pkg::dp_cmd_t               cmd_i,
  output srtf_pkg::dp_sts_t               sts_o,
  input  logic [srtf_pkg::DATA_W-1:0]     arrival_time_i,
  input  logic [srtf_pkg::DATA_W-1:0]     burst_time_i,
  output logic                            ran_process_o,
  output logic [srtf_pkg::PIDX_W-1:0]     process_index_o,
  output logic                            finished_o,
  output logic [srtf_pkg::TIME_W-1:0]     finish_time_o,
  output logic [srtf_pkg::TIME_W-1:0]     turnaround_time_o,
  output logic [srtf_pkg::TIME_W-1:0]     waiting_time_o,
  output logic                            all_done_o,
  output logic [srtf_pkg::TIME_W-1:0]     current_time_o,
  output logic [srtf_pkg::SUM_W-1:0]      total_waiting_o,
  output logic [srtf_pkg::SUM_W-1:0]      total_turnaround_o
);
  import srtf_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCESSES);

  // control state
  logic [CNT_W-1:0]  entry_cnt_q, done_cnt_q;
  logic [TIME_W-1:0] time_q;
  logic [SUM_W-1:0]  wsum_q, tsum_q;
  logic [IDX_W-1:0]  scan_idx_q;
  logic              cmp_vld_q, found_q, fin_q;

  // payload state
  logic [IDX_W-1:0]  best_idx_q;
  logic [DATA_W-1:0] best_rem_q, best_arr_q, best_bur_q;
  logic [TIME_W-1:0] tat_q, wt_q;

  // table ports
  logic                    load_ok;
  logic                    rem_we;
  logic [IDX_W-1:0]        rem_waddr;
  logic [DATA_W-1:0]       rem_wdata, rem_rd;
  logic [2*DATA_W-1:0]     ab_rd;
  logic [DATA_W-1:0]       arr_rd, bur_rd;

  assign load_ok   = cmd_i.load && (entry_cnt_q < CNT_FULL) && (burst_time_i != '0);
  assign rem_we    = load_ok || (cmd_i.step && found_q);
  assign rem_waddr = cmd_i.load ? entry_cnt_q[IDX_W-1:0] : best_idx_q;
  assign rem_wdata = cmd_i.load ? burst_time_i : best_rem_q - DATA_W'(1);
  assign arr_rd    = ab_rd[2*DATA_W-1:DATA_W];
  assign bur_rd    = ab_rd[DATA_W-1:0];

  // arrival and burst, written once per load
  srtf_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_PROCESSES)) u_ab_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (entry_cnt_q[IDX_W-1:0]),
    .wdata_i ({arrival_time_i, burst_time_i}),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_idx_q),
    .rdata_o (ab_rd)
  );

  // remaining time, written on load and on each run
  srtf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PROCESSES)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_idx_q),
    .rdata_o (rem_rd)
  );

  // status
  assign sts_o.scan_last = ({{(CNT_W - IDX_W){1'b0}}, scan_idx_q} == entry_cnt_q - CNT_W'(1));
  assign sts_o.all_done  = (done_cnt_q >= entry_cnt_q);

  // candidate test on the entry read last cycle
  logic cand_ok, cand_better;
  assign cand_ok     = ({{(TIME_W - DATA_W){1'b0}}, arr_rd} <= time_q) && (rem_rd != '0);
  assign cand_better = !found_q || (rem_rd < best_rem_q);

  // saturating time step and totals
  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] tat_calc;
  logic [SUM_W:0]    tsum_add, wsum_add;
  assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
  assign tat_calc = time_q - {{(TIME_W - DATA_W){1'b0}}, best_arr_q};
  assign tsum_add = {1'b0, tsum_q} + (SUM_W + 1)'(tat_q);
  assign wsum_add = {1'b0, wsum_q} + (SUM_W + 1)'(wt_q);

  // low four bits of the picked index
  logic [IDX_W+PIDX_W-1:0] idx_ext;
  assign idx_ext = {{PIDX_W{1'b0}}, best_idx_q};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
      done_cnt_q  <= '0;
      time_q      <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.clear) begin
        entry_cnt_q <= '0;
        done_cnt_q  <= '0;
        time_q      <= '0;
        wsum_q      <= '0;
        tsum_q      <= '0;
      end
      if (load_ok) begin
        entry_cnt_q <= entry_cnt_q + CNT_W'(1);
      end
      if (cmd_i.tick_init) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        fin_q      <= 1'b0;
      end
      if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      if (cmp_vld_q && cand_ok) begin
        found_q <= 1'b1;
      end
      if (cmd_i.step) begin
        time_q <= time_inc;
        if (found_q && (best_rem_q == DATA_W'(1))) begin
          fin_q      <= 1'b1;
          done_cnt_q <= done_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.wt_en && fin_q) begin
        tsum_q <= tsum_add[SUM_W] ? SUM_MAX : tsum_add[SUM_W-1:0];
      end
      if (cmd_i.sum_en && fin_q) begin
        wsum_q <= wsum_add[SUM_W] ? SUM_MAX : wsum_add[SUM_W-1:0];
      end
    end
  end

  // best candidate and per-process times
  always_ff @(posedge clk_i) begin
    if (cmp_vld_q && cand_ok && cand_better) begin
      best_idx_q <= scan_idx_q - IDX_W'(1);
      best_rem_q <= rem_rd;
      best_arr_q <= arr_rd;
      best_bur_q <= bur_rd;
    end
    if (cmd_i.tat_en) begin
      tat_q <= tat_calc;
    end
    if (cmd_i.wt_en) begin
      wt_q <= (tat_q > {{(TIME_W - DATA_W){1'b0}}, best_bur_q})
              ? tat_q - {{(TIME_W - DATA_W){1'b0}}, best_bur_q} : '0;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      ran_process_o      <= found_q;
      process_index_o    <= found_q ? idx_ext[PIDX_W-1:0] : '0;
      finished_o         <= fin_q;
      finish_time_o      <= fin_q ? time_q : '0;
      turnaround_time_o  <= fin_q ? tat_q : '0;
      waiting_time_o     <= fin_q ? wt_q : '0;
      all_done_o         <= (done_cnt_q >= entry_cnt_q);
      current_time_o     <= time_q;
      total_waiting_o    <= wsum_q;
      total_turnaround_o <= tsum_q;
    end
  end

endmodule

// ===== rtl/srtf_preemptive_scheduler.sv =====
// top level of the shortest-remaining-time-first scheduler
// joins srtf_ctrl and srtf_dpath; uses srtf_pkg
//
//  channel | signals                                  | transfer
//  --------+------------------------------------------+----------------------------
//  command | start, command_i, arrival_time_i,        | start high and busy low
//          | burst_time_i                             |
//  result  | result_valid_o and ten result fields     | each cycle result_valid_o
//
// load and clear give no result.
// a tick is not accepted again until it is through: the datapath reads one table
// entry per cycle through the memory read port, then works in turn on time,
// turnaround, waiting and totals before the report.
// a tick with nothing left to run goes straight to the report.
// reset returns to an empty table with time and totals at zero; no memory clearing.
// results show for one cycle; the receiver cannot stall them.
module srtf_preemptive_scheduler #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [srtf_pkg::CMD_W-1:0]      command_i,
  input  logic [srtf_pkg::DATA_W-1:0]     arrival_time_i,
  input  logic [srtf_pkg::DATA_W-1:0]     burst_time_i,
  output logic                            result_valid_o,
  output logic                            ran_process_o,
  output logic [srtf_pkg::PIDX_W-1:0]     process_index_o,
  output logic                            finished_o,
  output logic [srtf_pkg::TIME_W-1:0]     finish_time_o,
  output logic [srtf_pkg::TIME_W-1:0]     turnaround_time_o,
  output logic [srtf_pkg::TIME_W-1:0]     waiting_time_o,
  output logic                            all_done_o,
  output logic [srtf_pkg::TIME_W-1:0]     current_time_o,
  output logic [srtf_pkg::SUM_W-1:0]      total_waiting_o,
  output logic [srtf_pkg::SUM_W-1:0]      total_turnaround_o
);
  import srtf_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer
  srtf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .command_i      (command_i),
    .sts_i          (dp_sts),
    .cmd_o          (dp_cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // tables and arithmetic
  srtf_dpath #(.MAX_PROCESSES(MAX_PROCESSES)) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .sts_o              (dp_sts),
    .arrival_time_i     (arrival_time_i),
    .burst_time_i       (burst_time_i),
    .ran_process_o      (ran_process_o),
    .process_index_o    (process_index_o),
    .finished_o         (finished_o),
    .finish_time_o      (finish_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .waiting_time_o     (waiting_time_o),
    .all_done_o         (all_done_o),
    .current_time_o     (current_time_o),
    .total_waiting_o    (total_waiting_o),
    .total_turnaround_o (total_turnaround_o)
  );

endmodule

// ===== rtl/srtf_checker.sv =====
// port-level checks of the srtf scheduler, bound to the top level
// uses srtf_pkg; attaches with the bind at the end of this file
module srtf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [srtf_pkg::CMD_W-1:0]  command_i,
  input logic                        result_valid_o,
  input logic                        ran_process_o,
  input logic                        finished_o,
  input logic [srtf_pkg::TIME_W-1:0] turnaround_time_o,
  input logic [srtf_pkg::TIME_W-1:0] waiting_time_o
);
  import srtf_pkg::*;

  // results never come in consecutive cycles
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // a result shows only once the block can take the next command
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  // a load gives no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_LOAD)) |=> !result_valid_o)
    else $error("result after a load");

  // completion only for a process that ran
  a_fin_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !ran_process_o) |-> !finished_o)
    else $error("finished without a run");

  // waiting never exceeds turnaround
  a_wait_le_tat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && finished_o) |-> (waiting_time_o <= turnaround_time_o))
    else $error("waiting time above turnaround");

endmodule

bind srtf_preemptive_scheduler srtf_checker u_srtf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .command_i         (command_i),
  .result_valid_o    (result_valid_o),
  .ran_process_o     (ran_process_o),
  .finished_o        (finished_o),
  .turnaround_time_o (turnaround_time_o),
  .waiting_time_o    (waiting_time_o)
);

// ===== verif/srtf_sched_checker.sv =====
// result checker for the srtf scheduler: predicts every tick report and compares it
// with the transfer seen on the result port; depends on srtf_pkg
`timescale 1ns / 1ps

module srtf_sched_checker #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [srtf_pkg::CMD_W-1:0]  command_i,
  input  logic [srtf_pkg::DATA_W-1:0] arrival_time_i,
  input  logic [srtf_pkg::DATA_W-1:0] burst_time_i,
  input  logic                        result_valid_i,
  input  logic                        ran_process_i,
  input  logic [srtf_pkg::PIDX_W-1:0] process_index_i,
  input  logic                        finished_i,
  input  logic [srtf_pkg::TIME_W-1:0] finish_time_i,
  input  logic [srtf_pkg::TIME_W-1:0] turnaround_time_i,
  input  logic [srtf_pkg::TIME_W-1:0] waiting_time_i,
  input  logic                        all_done_i,
  input  logic [srtf_pkg::TIME_W-1:0] current_time_i,
  input  logic [srtf_pkg::SUM_W-1:0]  total_waiting_i,
  input  logic [srtf_pkg::SUM_W-1:0]  total_turnaround_i,
  output int                          errors_o,
  output int                          pending_o
);
  import srtf_pkg::*;

  typedef struct packed {
    logic              ran;
    logic [PIDX_W-1:0] idx;
    logic              fin;
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic              all_done;
    logic [TIME_W-1:0] cur_time;
    logic [SUM_W-1:0]  wait_sum;
    logic [SUM_W-1:0]  tat_sum;
  } tick_report_t;

  // scheduler state as the block should hold it
  logic [DATA_W-1:0] arr_tbl    [MAX_PROCESSES];
  logic [DATA_W-1:0] burst_tbl  [MAX_PROCESSES];
  logic [DATA_W-1:0] remain_tbl [MAX_PROCESSES];
  int unsigned       n_loaded;
  int unsigned       n_done;
  logic [TIME_W-1:0] sched_time;
  logic [SUM_W-1:0]  wait_total;
  logic [SUM_W-1:0]  tat_total;

  tick_report_t tick_reports_q[$];
  int           n_errors;

  assign errors_o  = n_errors;
  assign pending_o = tick_reports_q.size();

  function automatic void clear_table();
    n_loaded   = 0;
    n_done     = 0;
    sched_time = '0;
    wait_total = '0;
    tat_total  = '0;
  endfunction

  // loads into a full table or with zero burst are dropped
  function automatic void load_process(logic [DATA_W-1:0] arr, logic [DATA_W-1:0] bur);
    if (n_loaded < MAX_PROCESSES && bur != '0) begin
      arr_tbl[n_loaded]    = arr;
      burst_tbl[n_loaded]  = bur;
      remain_tbl[n_loaded] = bur;
      n_loaded++;
    end
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [TIME_W-1:0] add);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(add);
    return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // one time unit: least remaining time among arrived work, lowest index on ties
  function automatic tick_report_t run_tick();
    tick_report_t r;
    int           pick;
    bit           found;
    int           i;
    r = '0;
    if (n_done < n_loaded) begin
      found = 1'b0;
      pick  = 0;
      for (i = 0; i < n_loaded; i++) begin
        if (TIME_W'(arr_tbl[i]) <= sched_time && remain_tbl[i] != '0 &&
            (!found || remain_tbl[i] < remain_tbl[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (sched_time != TIME_MAX) sched_time = sched_time + 1'b1;
      if (found) begin
        r.ran = 1'b1;
        r.idx = PIDX_W'(pick);
        remain_tbl[pick] = remain_tbl[pick] - 1'b1;
        if (remain_tbl[pick] == '0) begin
          n_done++;
          r.fin    = 1'b1;
          r.finish = sched_time;
          r.tat    = sched_time - TIME_W'(arr_tbl[pick]);
          // saturated time can leave turnaround below burst
          r.wt     = (r.tat > TIME_W'(burst_tbl[pick])) ? r.tat - TIME_W'(burst_tbl[pick]) : '0;
          wait_total = sat_sum(wait_total, r.wt);
          tat_total  = sat_sum(tat_total, r.tat);
        end
      end
    end
    r.all_done = (n_done >= n_loaded);
    r.cur_time = sched_time;
    r.wait_sum = wait_total;
    r.tat_sum  = tat_total;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("[%0t] checker: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // compare the result transfer first, then take the command transfer
  always @(posedge clk_i or negedge rst_ni) begin
    tick_report_t exp_r;
    if (!rst_ni) begin
      clear_table();
      tick_reports_q.delete();
      n_errors = 0;
    end else begin
      if (result_valid_i) begin
        if (tick_reports_q.size() == 0) begin
          report_mismatch("result transfer with no tick outstanding");
        end else begin
          exp_r = tick_reports_q.pop_front();
          check_field("ran_process", ran_process_i, exp_r.ran);
          check_field("process_index", process_index_i, exp_r.idx);
          check_field("finished", finished_i, exp_r.fin);
          check_field("finish_time", finish_time_i, exp_r.finish);
          check_field("turnaround_time", turnaround_time_i, exp_r.tat);
          check_field("waiting_time", waiting_time_i, exp_r.wt);
          check_field("all_done", all_done_i, exp_r.all_done);
          check_field("current_time", current_time_i, exp_r.cur_time);
          check_field("total_waiting", total_waiting_i, exp_r.wait_sum);
          check_field("total_turnaround", total_turnaround_i, exp_r.tat_sum);
        end
      end
      if (start && !busy) begin
        case (command_i)
          CMD_LOAD:  load_process(arrival_time_i, burst_time_i);
          CMD_TICK:  tick_reports_q.push_back(run_tick());
          CMD_CLEAR: clear_table();
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_srtf_preemptive_scheduler.sv =====
// testbench top for the srtf scheduler: drives directed and random command transfers
// and gives the verdict; depends on srtf_pkg, srtf_preemptive_scheduler, srtf_sched_checker
`timescale 1ns / 1ps

module tb_srtf_preemptive_scheduler;
  import srtf_pkg::*;

  localparam int unsigned      MAX_PROCESSES  = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
  localparam int               ITEM_TARGET    = 1100;
  localparam int               QUIET_TAIL     = 150;
  localparam int               WATCHDOG_LIMIT = 2000;
  localparam int               DRAIN_CYCLES   = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command_i;
  logic [DATA_W-1:0]   arrival_time_i;
  logic [DATA_W-1:0]   burst_time_i;
  logic                result_valid_o;
  logic                ran_process_o;
  logic [PIDX_W-1:0]   process_index_o;
  logic                finished_o;
  logic [TIME_W-1:0]   finish_time_o;
  logic [TIME_W-1:0]   turnaround_time_o;
  logic [TIME_W-1:0]   waiting_time_o;
  logic                all_done_o;
  logic [TIME_W-1:0]   current_time_o;
  logic [SUM_W-1:0]    total_waiting_o;
  logic [SUM_W-1:0]    total_turnaround_o;

  int errors;
  int pending;
  int items_sent;
  int stall_cycles;
  int batch_no;
  int i;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  srtf_preemptive_scheduler #(.MAX_PROCESSES(MAX_PROCESSES)) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .arrival_time_i     (arrival_time_i),
    .burst_time_i       (burst_time_i),
    .result_valid_o     (result_valid_o),
    .ran_process_o      (ran_process_o),
    .process_index_o    (process_index_o),
    .finished_o         (finished_o),
    .finish_time_o      (finish_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .waiting_time_o     (waiting_time_o),
    .all_done_o         (all_done_o),
    .current_time_o     (current_time_o),
    .total_waiting_o    (total_waiting_o),
    .total_turnaround_o (total_turnaround_o)
  );

  srtf_sched_checker #(.MAX_PROCESSES(MAX_PROCESSES)) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .arrival_time_i     (arrival_time_i),
    .burst_time_i       (burst_time_i),
    .result_valid_i     (result_valid_o),
    .ran_process_i      (ran_process_o),
    .process_index_i    (process_index_o),
    .finished_i         (finished_o),
    .finish_time_i      (finish_time_o),
    .turnaround_time_i  (turnaround_time_o),
    .waiting_time_i     (waiting_time_o),
    .all_done_i         (all_done_o),
    .current_time_i     (current_time_o),
    .total_waiting_i    (total_waiting_o),
    .total_turnaround_i (total_turnaround_o),
    .errors_o           (errors),
    .pending_o          (pending)
  );

  // watchdog: cycles with neither a command nor a result transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one command transfer; entered and left at a falling edge
  task automatic issue(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] arr,
                       input logic [DATA_W-1:0] bur);
    int gap;
    if (items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
      gap            = $urandom_range(1, 15);
      start          <= 1'b0;
      command_i      <= CMD_W'($urandom);
      arrival_time_i <= DATA_W'($urandom);
      burst_time_i   <= DATA_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= code;
    arrival_time_i <= arr;
    burst_time_i   <= bur;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    if (code != CMD_UNUSED) items_sent++;
  endtask

  // hold the sender until every tick report is back
  task automatic drain_wait();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // clear, load a process set, then tick it through with some noise mixed in
  task automatic run_batch(input int nb);
    int                n_loads;
    int                n_ticks;
    int                arr_max;
    int                burst_sum;
    int                k;
    logic [DATA_W-1:0] arr;
    logic [DATA_W-1:0] bur;
    issue(CMD_CLEAR, DATA_W'($urandom), DATA_W'($urandom));
    n_loads   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
    arr_max   = 0;
    burst_sum = 0;
    for (k = 0; k < n_loads; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        // wide values: late arrivals, long or zero bursts
        arr = DATA_W'($urandom);
        bur = ($urandom_range(0, 2) == 0) ? '0 : DATA_W'($urandom);
      end else begin
        arr = DATA_W'($urandom_range(0, 12));
        bur = DATA_W'($urandom_range(1, 6));
        if (arr > arr_max) arr_max = arr;
        burst_sum += bur;
      end
      issue(CMD_LOAD, arr, bur);
      if ($urandom_range(0, 19) == 0) issue(CMD_UNUSED, DATA_W'($urandom), DATA_W'($urandom));
    end
    n_ticks = arr_max + burst_sum + $urandom_range(1, 3);
    if (n_ticks > 80) n_ticks = 80;
    for (k = 0; k < n_ticks; k++) begin
      if (k == n_ticks / 2 && (nb == 0 || $urandom_range(0, 5) == 0)) drain_wait();
      case ($urandom_range(0, 59))
        0: issue(CMD_LOAD, DATA_W'($urandom_range(0, 40)), DATA_W'($urandom_range(0, 8)));
        1: issue(CMD_UNUSED, DATA_W'($urandom), DATA_W'($urandom));
        2: issue(CMD_CLEAR, DATA_W'($urandom), DATA_W'($urandom));
        default: issue(CMD_TICK, DATA_W'($urandom), DATA_W'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = CMD_LOAD;
    arrival_time_i = '0;
    burst_time_i   = '0;
    items_sent     = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, unknown code, zero burst, idle tick, one completion
    issue(CMD_TICK, '1, '1);
    issue(CMD_UNUSED, '1, '1);
    issue(CMD_LOAD, '1, '0);
    issue(CMD_LOAD, 16'd2, 16'd1);
    issue(CMD_TICK, '0, '0);
    issue(CMD_TICK, '0, '0);
    issue(CMD_TICK, '0, '0);
    issue(CMD_TICK, '0, '0);
    issue(CMD_CLEAR, '0, '0);
    // full table with ties, longest burst first, then one load too many
    for (i = 0; i < MAX_PROCESSES; i++) begin
      issue(CMD_LOAD, DATA_W'(i % 4), (i == 0) ? '1 : DATA_W'((i % 3) + 1));
    end
    issue(CMD_LOAD, '0, 16'd1);

    batch_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_batch(batch_no);
      batch_no++;
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/srtf_pkg.sv
rtl/srtf_ram.sv
rtl/srtf_ctrl.sv
rtl/srtf_dpath.sv
rtl/srtf_preemptive_scheduler.sv
rtl/srtf_checker.sv
verif/srtf_sched_checker.sv
verif/tb_srtf_preemptive_scheduler.sv
